// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file stp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ===== sv/stp_pkg.sv =====
// ----------------------------------------------------------------------------
// stp_pkg
// Types, character codes and classification helpers of the S-expression
// token scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned FIELD_W         = 16;

  typedef enum logic [3:0] {
    KIND_EOF     = 4'd0,
    KIND_QUOTE   = 4'd1,
    KIND_LPAREN  = 4'd2,
    KIND_RPAREN  = 4'd3,
    KIND_STRING  = 4'd4,
    KIND_CHAR    = 4'd5,
    KIND_NUMBER  = 4'd6,
    KIND_IDENT   = 4'd7,
    KIND_ILLEGAL = 4'd8
  } kind_e;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  typedef struct packed {
    kind_e                kind;
    logic [FIELD_W-1:0]   start;
    logic [FIELD_W-1:0]   length;
    logic [FIELD_W-1:0]   line;
    logic [BYTE_W-1:0]    chr;
    logic                 last;
  } tok_t;

  // Tokens that one byte produces: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } scan_res_t;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  // Special marks allowed in identifiers: ? ! < > = % ^ * + - / \ _ &
  function automatic logic is_mark(input logic [7:0] b);
    is_mark = (b == 8'h3F) || (b == 8'h21) || (b == 8'h3C) || (b == 8'h3E) ||
              (b == 8'h3D) || (b == 8'h25) || (b == 8'h5E) || (b == 8'h2A) ||
              (b == 8'h2B) || (b == 8'h2D) || (b == 8'h2F) || (b == 8'h5C) ||
              (b == 8'h5F) || (b == 8'h26);
  endfunction

endpackage

`default_nettype wire

// ===== sv/stp_skid.sv =====
// ----------------------------------------------------------------------------
// stp_skid
// Input register with a skid slot, so the upstream ready is a register.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_skid (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_valid_i,
  output logic                           s_ready_o,
  input  wire logic [stp_pkg::BYTE_W-1:0] s_data_i,
  output logic                           valid_o,
  output logic [stp_pkg::BYTE_W-1:0]     data_o,
  input  wire logic                      take_i
);

  logic                       main_valid_q, skid_valid_q;
  logic [stp_pkg::BYTE_W-1:0] main_q, skid_q;
  logic                       s_fire;

  assign s_ready_o = !skid_valid_q;
  assign s_fire    = s_valid_i && !skid_valid_q;
  assign valid_o   = main_valid_q;
  assign data_o    = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (main_valid_q && !take_i) begin
      // The main slot is held; a transaction arriving now parks in the skid slot.
      if (s_fire) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      main_valid_q <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= s_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (main_valid_q && !take_i) begin
      if (s_fire) begin
        skid_q <= s_data_i;
      end
    end else if (skid_valid_q) begin
      main_q <= skid_q;
    end else if (s_fire) begin
      main_q <= s_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stp_scan.sv =====
// ----------------------------------------------------------------------------
// stp_scan
// Scanner state and the per-byte decode that yields up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_scan #(
  parameter int unsigned OFFSET_BITS = stp_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [stp_pkg::BYTE_W-1:0] byte_i,
  input  wire logic                       take_i,
  output stp_pkg::scan_res_t              res_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_STRING,
    MODE_STRESC,
    MODE_TILDE,
    MODE_NUMBER,
    MODE_IDENT
  } mode_e;

  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
  localparam logic [OFFSET_BITS-1:0] POS_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
  localparam logic [15:0]            LINE_MAX = 16'hFFFF;

  mode_e                  mode_q, mode_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d, start_q, start_d;
  logic [15:0]            line_q, line_d;

  logic [OFFSET_BITS-1:0] len;
  logic [15:0]            line_inc;

  logic                   idle_emit, idle_set_start, idle_nl, idle_eof;
  stp_pkg::kind_e         idle_kind;
  mode_e                  idle_mode;
  logic [OFFSET_BITS-1:0] idle_start;
  stp_pkg::tok_t          idle_tok, slice_tok;

  logic                   run_idle, have_slice, do_eof;
  stp_pkg::scan_res_t     res;

  function automatic logic [15:0] sat16(input logic [OFFSET_BITS-1:0] v);
    logic [47:0] w;
    w = 48'(v);
    sat16 = (|w[47:16]) ? 16'hFFFF : w[15:0];
  endfunction

  assign len      = (pos_q >= start_q) ? (pos_q - start_q) : '0;
  assign line_inc = (line_q < LINE_MAX) ? (line_q + 16'd1) : line_q;

  // Decode of a byte seen between tokens.
  always_comb begin
    idle_emit      = 1'b0;
    idle_kind      = stp_pkg::KIND_ILLEGAL;
    idle_mode      = MODE_IDLE;
    idle_set_start = 1'b0;
    idle_start     = pos_q;
    idle_nl        = 1'b0;
    idle_eof       = 1'b0;
    if (byte_i == stp_pkg::CH_NUL) begin
      idle_emit = 1'b1;
      idle_kind = stp_pkg::KIND_EOF;
      idle_eof  = 1'b1;
    end else if (byte_i == stp_pkg::CH_SPACE || byte_i == stp_pkg::CH_TAB ||
                 byte_i == stp_pkg::CH_CR) begin
      idle_mode = MODE_IDLE;
    end else if (byte_i == stp_pkg::CH_LF) begin
      idle_nl = 1'b1;
    end else if (byte_i == stp_pkg::CH_SEMI) begin
      idle_mode = MODE_COMMENT;
    end else if (byte_i == stp_pkg::CH_QUOTE) begin
      idle_emit = 1'b1;
      idle_kind = stp_pkg::KIND_QUOTE;
    end else if (byte_i == stp_pkg::CH_LPAREN) begin
      idle_emit = 1'b1;
      idle_kind = stp_pkg::KIND_LPAREN;
    end else if (byte_i == stp_pkg::CH_RPAREN) begin
      idle_emit = 1'b1;
      idle_kind = stp_pkg::KIND_RPAREN;
    end else if (byte_i == stp_pkg::CH_DQUOTE) begin
      // The string body starts after the opening quote.
      idle_mode      = MODE_STRING;
      idle_set_start = 1'b1;
      idle_start     = (pos_q != POS_MAX) ? (pos_q + POS_ONE) : POS_MAX;
    end else if (byte_i == stp_pkg::CH_TILDE) begin
      idle_mode      = MODE_TILDE;
      idle_set_start = 1'b1;
    end else if (stp_pkg::is_digit(byte_i)) begin
      idle_mode      = MODE_NUMBER;
      idle_set_start = 1'b1;
    end else if (stp_pkg::is_alpha(byte_i) || stp_pkg::is_mark(byte_i)) begin
      idle_mode      = MODE_IDENT;
      idle_set_start = 1'b1;
    end else begin
      idle_emit = 1'b1;
      idle_kind = stp_pkg::KIND_ILLEGAL;
    end
  end

  always_comb begin
    idle_tok        = '0;
    idle_tok.kind   = idle_kind;
    idle_tok.start  = sat16(pos_q);
    idle_tok.line   = line_q;
    slice_tok       = '0;
    slice_tok.kind  = stp_pkg::KIND_STRING;
    slice_tok.start = sat16(start_q);
    slice_tok.length = sat16(len);
    slice_tok.line  = line_q;
  end

  always_comb begin
    res        = '0;
    mode_d     = mode_q;
    pos_d      = (pos_q != POS_MAX) ? (pos_q + POS_ONE) : pos_q;
    start_d    = start_q;
    line_d     = line_q;
    run_idle   = 1'b0;
    have_slice = 1'b0;
    do_eof     = 1'b0;

    unique case (mode_q)
      MODE_COMMENT: begin
        // End of text and the closing newline both behave as between tokens.
        if (byte_i == stp_pkg::CH_NUL || byte_i == stp_pkg::CH_LF) begin
          run_idle = 1'b1;
        end
      end
      MODE_STRING, MODE_STRESC: begin
        if (byte_i == stp_pkg::CH_NUL) begin
          res.count = 2'd2;
          res.tok0  = slice_tok;
          res.tok1  = idle_tok;
          do_eof    = 1'b1;
        end else if (mode_q == MODE_STRESC) begin
          mode_d = MODE_STRING;
        end else if (byte_i == stp_pkg::CH_DQUOTE) begin
          res.count = 2'd1;
          res.tok0  = slice_tok;
          mode_d    = MODE_IDLE;
        end else if (byte_i == stp_pkg::CH_BSLASH) begin
          mode_d = MODE_STRESC;
        end
      end
      MODE_TILDE: begin
        res.tok0        = slice_tok;
        res.tok0.kind   = stp_pkg::KIND_CHAR;
        res.tok0.length = '0;
        res.tok0.chr    = byte_i;
        mode_d          = MODE_IDLE;
        if (byte_i == stp_pkg::CH_NUL) begin
          res.count = 2'd2;
          res.tok1  = idle_tok;
          do_eof    = 1'b1;
        end else begin
          res.count = 2'd1;
        end
      end
      MODE_NUMBER: begin
        if (!stp_pkg::is_digit(byte_i)) begin
          have_slice     = 1'b1;
          res.tok0       = slice_tok;
          res.tok0.kind  = stp_pkg::KIND_NUMBER;
          run_idle       = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (!(stp_pkg::is_alpha(byte_i) || stp_pkg::is_digit(byte_i) ||
              stp_pkg::is_mark(byte_i))) begin
          have_slice     = 1'b1;
          res.tok0       = slice_tok;
          res.tok0.kind  = stp_pkg::KIND_IDENT;
          run_idle       = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    // A byte that ends a number or identifier is scanned again from idle.
    if (run_idle) begin
      mode_d = idle_mode;
      if (idle_set_start) begin
        start_d = idle_start;
      end
      if (idle_nl) begin
        line_d = line_inc;
      end
      do_eof = idle_eof;
      if (idle_emit && have_slice) begin
        res.count = 2'd2;
        res.tok1  = idle_tok;
      end else if (idle_emit) begin
        res.count = 2'd1;
        res.tok0  = idle_tok;
      end else if (have_slice) begin
        res.count = 2'd1;
      end
    end

    if (do_eof) begin
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      start_d = '0;
      line_d  = 16'd1;
    end

    if (res.count == 2'd1) begin
      res.tok0.last = 1'b1;
    end
    if (res.count == 2'd2) begin
      res.tok1.last = 1'b1;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      line_q  <= 16'd1;
    end else if (take_i) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      line_q  <= line_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stp_out.sv =====
// ----------------------------------------------------------------------------
// stp_out
// Result register plus one pending slot for the second token of a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module stp_out (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire stp_pkg::scan_res_t res_i,
  output logic                    can_take_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output stp_pkg::tok_t           m_tok_o
);

  logic          out_valid_q, pend_valid_q;
  stp_pkg::tok_t out_q, pend_q;
  logic          pop;

  assign pop        = out_valid_q && m_ready_i;
  // A new byte may be decoded only when both of its tokens have room.
  assign can_take_o = !pend_valid_q && (!out_valid_q || m_ready_i);
  assign m_valid_o  = out_valid_q;
  assign m_tok_o    = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (take_i && res_i.count != 2'd0) begin
      out_valid_q  <= 1'b1;
      pend_valid_q <= (res_i.count == 2'd2);
    end else if (pop) begin
      out_valid_q  <= pend_valid_q;
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && res_i.count != 2'd0) begin
      out_q  <= res_i.tok0;
      pend_q <= res_i.tok1;
    end else if (pop && pend_valid_q) begin
      out_q <= pend_q;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sexpr_token_scanner.sv =====
// ----------------------------------------------------------------------------
// sexpr_token_scanner
// Streaming lexer for S-expression text: one text byte in, tokens out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] text byte (0 ends the text)
//  m_axis    out        tuser token kind, tdata offsets/length/line/char,
//                       tlast on the final token of a byte
//
//  A byte is decoded combinationally from the input register, and its tokens
//  are registered into the result register when the byte is taken.
//  Sustained rate is one byte per cycle while m_axis accepts tokens; a byte
//  that yields two tokens holds the decoder while the second token sits in the
//  pending slot behind the result register.
//  Reset returns the scanner to idle, offset 0, line 1; stalls on m_axis
//  back up through the skid slot, which keeps s_axis_tready registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sexpr_token_scanner #(
  parameter int unsigned OFFSET_BITS = stp_pkg::OFFSET_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // [15:0] start_offset, [31:16] token_length,
                                           // [47:32] line_no, [55:48] char_value
  output logic [3:0]       m_axis_tuser,   // [3:0] token_kind
  output logic             m_axis_tlast    // last_of_run
);

  logic                       byte_valid, can_take, take;
  logic [stp_pkg::BYTE_W-1:0] byte_data;
  stp_pkg::scan_res_t         res;
  stp_pkg::tok_t              tok;

  assign take = byte_valid && can_take;

  stp_skid u_skid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .valid_o   (byte_valid),
    .data_o    (byte_data),
    .take_i    (take)
  );

  stp_scan #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_data),
    .take_i (take),
    .res_o  (res)
  );

  stp_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .res_i      (res),
    .can_take_o (can_take),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_tok_o    (tok)
  );

  assign m_axis_tdata = {tok.chr, tok.line, tok.length, tok.start};
  assign m_axis_tuser = tok.kind;
  assign m_axis_tlast = tok.last;

endmodule

`default_nettype wire

// ===== sv/stp_checker.sv =====
// ----------------------------------------------------------------------------
// stp_checker
// Port-level checks of the token scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module stp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [55:0] m_axis_tdata,
  input wire logic [3:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  logic no_slice;

  // Token kinds that carry no slice length.
  assign no_slice = (m_axis_tuser == stp_pkg::KIND_EOF) ||
                    (m_axis_tuser == stp_pkg::KIND_QUOTE) ||
                    (m_axis_tuser == stp_pkg::KIND_LPAREN) ||
                    (m_axis_tuser == stp_pkg::KIND_RPAREN) ||
                    (m_axis_tuser == stp_pkg::KIND_CHAR) ||
                    (m_axis_tuser == stp_pkg::KIND_ILLEGAL);

  `ASSERT_PROP(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled token changed")
  `ASSERT_NEVER(a_kind_range, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser > stp_pkg::KIND_ILLEGAL), "token kind out of range")
  `ASSERT_PROP(a_eof_last, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == stp_pkg::KIND_EOF) |-> m_axis_tlast, "end-of-text token is not last of its byte")
  `ASSERT_PROP(a_no_length, clk_i, rst_ni, m_axis_tvalid && no_slice |-> (m_axis_tdata[31:16] == 16'd0), "length on a token without a slice")
  `ASSERT_NEVER(a_line_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[47:32] == 16'd0), "line number zero")

endmodule

bind sexpr_token_scanner stp_checker u_stp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/sv/sexpr_token_scanner_test.sv =====
// ----------------------------------------------------------------------------
// sexpr_token_scanner_test
// Self-checking bench for the S-expression token scanner. Text bytes go in on
// the input stream with random gaps; a scoreboard lexes every accepted byte
// and checks each emitted token, field by field, against the oldest pending
// prediction. It covers directed corner texts and about 1600 bytes of random
// texts.
// ----------------------------------------------------------------------------
module sexpr_token_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HALF_PERIOD  = 4;
  localparam int unsigned IDLE_PCT     = 12;
  localparam int unsigned QUEUE_AHEAD  = 256;
  localparam int unsigned LONG_STALL   = 300;
  localparam int unsigned RANDOM_BYTES = 1600;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;
  localparam logic [15:0] LINE_MAX     = 16'hFFFF;

  typedef enum logic [2:0] {
    LX_IDLE,
    LX_COMMENT,
    LX_STRING,
    LX_ESCAPE,
    LX_TILDE,
    LX_NUMBER,
    LX_WORD
  } lex_mode_e;

  typedef struct {
    logic [7:0] ch;
    bit         hold;   // wait for all tokens to drain before offering
  } text_byte_t;

  typedef struct {
    stp_pkg::kind_e kind;
    logic [15:0]    start;
    logic [15:0]    length;
    logic [15:0]    line;
    logic [7:0]     chr;
    logic           last;
  } token_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] text_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;          // [15:0] start_offset, [31:16] token_length,
                                      // [47:32] line_no, [55:48] char_value
  logic [3:0]  m_axis_tuser;          // [3:0] token_kind
  logic        m_axis_tlast;          // last_of_run

  text_byte_t  text_q[$];
  token_exp_t  tokens_due[$];

  lex_mode_e   lex_mode;
  logic [15:0] lex_pos;
  logic [15:0] lex_tok_start;
  logic [15:0] lex_line;

  bit          offer_open = 1'b0;
  bit          pause_next = 1'b0;
  bit          pause_armed = 1'b0;
  int unsigned bytes_taken = 0;
  int unsigned bytes_queued = 0;
  int unsigned tokens_seen = 0;
  int unsigned errors = 0;
  int unsigned stall_at = 32'hFFFF_FFFF;
  int unsigned quiet_lo = 0;
  int unsigned quiet_hi = 0;
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;

  string       word_marks = "?!<>=%^*+-/\\_&";

  sexpr_token_scanner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Lexer prediction
  // --------------------------------------------------------------------------
  function automatic bit is_numeral(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic bit in_word(logic [7:0] b, bit with_digits);
    bit hit;
    hit = ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) ||
          (with_digits && is_numeral(b));
    for (int i = 0; i < word_marks.len(); i++) begin
      if (b == word_marks[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic void clear_scan();
    lex_mode      = LX_IDLE;
    lex_pos       = 16'd0;
    lex_tok_start = 16'd0;
    lex_line      = 16'd1;
  endfunction

  function automatic void bump_line();
    if (lex_line != LINE_MAX) lex_line++;
  endfunction

  function automatic void add_token(stp_pkg::kind_e kind, logic [15:0] start,
                                    logic [15:0] length, logic [7:0] chr);
    token_exp_t tok;
    tok.kind   = kind;
    tok.start  = start;
    tok.length = length;
    tok.line   = lex_line;
    tok.chr    = chr;
    tok.last   = 1'b0;
    tokens_due.push_back(tok);
  endfunction

  function automatic void end_of_text(logic [15:0] p);
    add_token(stp_pkg::KIND_EOF, p, 16'd0, 8'd0);
    clear_scan();
  endfunction

  function automatic void start_token(logic [7:0] b, logic [15:0] p);
    case (b)
      stp_pkg::CH_NUL: end_of_text(p);
      stp_pkg::CH_SPACE, stp_pkg::CH_TAB, stp_pkg::CH_CR: ;
      stp_pkg::CH_LF: bump_line();
      stp_pkg::CH_SEMI: lex_mode = LX_COMMENT;
      stp_pkg::CH_QUOTE: add_token(stp_pkg::KIND_QUOTE, p, 16'd0, 8'd0);
      stp_pkg::CH_LPAREN: add_token(stp_pkg::KIND_LPAREN, p, 16'd0, 8'd0);
      stp_pkg::CH_RPAREN: add_token(stp_pkg::KIND_RPAREN, p, 16'd0, 8'd0);
      stp_pkg::CH_DQUOTE: begin
        lex_mode      = LX_STRING;
        lex_tok_start = (p != POS_MAX) ? p + 16'd1 : POS_MAX;
      end
      stp_pkg::CH_TILDE: begin
        lex_mode      = LX_TILDE;
        lex_tok_start = p;
      end
      default: begin
        if (is_numeral(b)) begin
          lex_mode      = LX_NUMBER;
          lex_tok_start = p;
        end else if (in_word(b, 1'b0)) begin
          lex_mode      = LX_WORD;
          lex_tok_start = p;
        end else begin
          add_token(stp_pkg::KIND_ILLEGAL, p, 16'd0, 8'd0);
        end
      end
    endcase
  endfunction

  // Lexes one accepted byte and queues the tokens it completes.
  function automatic void scan_text_byte(logic [7:0] b);
    logic [15:0] p;
    logic [15:0] span;
    int          n_before;
    p        = lex_pos;
    span     = (p >= lex_tok_start) ? p - lex_tok_start : 16'd0;
    n_before = tokens_due.size();
    if (lex_pos != POS_MAX) lex_pos++;
    case (lex_mode)
      LX_COMMENT: begin
        if (b == stp_pkg::CH_NUL) begin
          end_of_text(p);
        end else if (b == stp_pkg::CH_LF) begin
          bump_line();
          lex_mode = LX_IDLE;
        end
      end
      LX_STRING, LX_ESCAPE: begin
        if (b == stp_pkg::CH_NUL) begin
          add_token(stp_pkg::KIND_STRING, lex_tok_start, span, 8'd0);
          end_of_text(p);
        end else if (lex_mode == LX_ESCAPE) begin
          lex_mode = LX_STRING;
        end else if (b == stp_pkg::CH_DQUOTE) begin
          add_token(stp_pkg::KIND_STRING, lex_tok_start, span, 8'd0);
          lex_mode = LX_IDLE;
        end else if (b == stp_pkg::CH_BSLASH) begin
          lex_mode = LX_ESCAPE;
        end
      end
      LX_TILDE: begin
        add_token(stp_pkg::KIND_CHAR, lex_tok_start, 16'd0, b);
        lex_mode = LX_IDLE;
        if (b == stp_pkg::CH_NUL) end_of_text(p);
      end
      LX_NUMBER: begin
        if (!is_numeral(b)) begin
          add_token(stp_pkg::KIND_NUMBER, lex_tok_start, span, 8'd0);
          lex_mode = LX_IDLE;
          start_token(b, p);
        end
      end
      LX_WORD: begin
        if (!in_word(b, 1'b1)) begin
          add_token(stp_pkg::KIND_IDENT, lex_tok_start, span, 8'd0);
          lex_mode = LX_IDLE;
          start_token(b, p);
        end
      end
      default: start_token(b, p);
    endcase
    if (tokens_due.size() > n_before) tokens_due[tokens_due.size() - 1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    if (errors < MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("token %0d %s: got %0h, expected %0h",
                                tokens_seen, name, got, want));
    end
  endtask

  task automatic check_token();
    token_exp_t want;
    if (tokens_due.size() == 0) begin
      report_mismatch($sformatf("token %0d of kind %0d arrived with none pending",
                                tokens_seen, m_axis_tuser));
    end else begin
      want = tokens_due.pop_front();
      check_field("kind", 32'(m_axis_tuser), 32'(want.kind));
      check_field("start_offset", 32'(m_axis_tdata[15:0]), 32'(want.start));
      check_field("token_length", 32'(m_axis_tdata[31:16]), 32'(want.length));
      check_field("line_no", 32'(m_axis_tdata[47:32]), 32'(want.line));
      check_field("char_value", 32'(m_axis_tdata[55:48]), 32'(want.chr));
      check_field("last_of_run", 32'(m_axis_tlast), 32'(want.last));
    end
    tokens_seen++;
  endtask

  function automatic int unsigned idle_percent();
    return (bytes_taken >= quiet_lo && bytes_taken < quiet_hi) ? 0 : IDLE_PCT;
  endfunction

  // Monitor: both channels are sampled at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_token();
      if (s_axis_tvalid && s_axis_tready) begin
        scan_text_byte(s_axis_tdata);
        void'(text_q.pop_front());
        offer_open = 1'b0;
        bytes_taken++;
      end
    end
  end

  // Driver: offers the head of the text queue, holding it until it is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!offer_open) begin
      if (text_q.size() != 0 && !(text_q[0].hold && tokens_due.size() != 0) &&
          $urandom_range(99) >= idle_percent()) begin
        s_axis_tdata  <= text_q[0].ch;
        s_axis_tvalid <= 1'b1;
        offer_open = 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!stall_done && bytes_taken >= stall_at) begin
      m_axis_tready <= 1'b0;
      stall_left = LONG_STALL;
      stall_done = 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_percent());
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_byte(logic [7:0] b);
    text_byte_t item;
    while (text_q.size() >= QUEUE_AHEAD) @(posedge clk_i);
    item.ch   = b;
    item.hold = pause_next;
    pause_next = 1'b0;
    text_q.push_back(item);
    bytes_queued++;
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_word_char(bit head);
    case ($urandom_range(2, head ? 1 : 0))
      0: return 8'($urandom_range("0", "9"));
      1: return word_marks[$urandom_range(word_marks.len() - 1)];
      default: return $urandom_range(1) ? 8'($urandom_range("a", "z"))
                                        : 8'($urandom_range("A", "Z"));
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0: return stp_pkg::CH_SPACE;
      1: return stp_pkg::CH_TAB;
      2: return stp_pkg::CH_CR;
      default: return stp_pkg::CH_LF;
    endcase
  endfunction

  task automatic put_string_body(int unsigned n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 15) begin
        push_byte(stp_pkg::CH_BSLASH);
        push_byte(8'($urandom_range(1, 255)));
      end else begin
        b = 8'($urandom_range(1, 255));
        if (b == stp_pkg::CH_DQUOTE || b == stp_pkg::CH_BSLASH) b = "a";
        if ($urandom_range(9) == 0) b = stp_pkg::CH_LF;
        push_byte(b);
      end
    end
  endtask

  task automatic put_comment_body(int unsigned n);
    logic [7:0] b;
    push_byte(stp_pkg::CH_SEMI);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(1, 255));
      push_byte((b == stp_pkg::CH_LF) ? stp_pkg::CH_SPACE : b);
    end
  endtask

  // One text of well-formed tokens with random content and some noise.
  task automatic add_random_text();
    int unsigned n_tok;
    int unsigned pick;
    n_tok = $urandom_range(12);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        push_byte(8'($urandom_range(1, 255)));
      end else if (pick < 30) begin
        push_byte(pick_word_char(1'b1));
        repeat ($urandom_range(6)) push_byte(pick_word_char(1'b0));
      end else if (pick < 48) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range("0", "9")));
      end else if (pick < 60) begin
        push_byte(stp_pkg::CH_DQUOTE);
        put_string_body($urandom_range(8));
        push_byte(stp_pkg::CH_DQUOTE);
      end else if (pick < 68) begin
        push_byte(stp_pkg::CH_TILDE);
        push_byte(8'($urandom_range(1, 255)));
      end else if (pick < 76) begin
        case ($urandom_range(2))
          0: push_byte(stp_pkg::CH_LPAREN);
          1: push_byte(stp_pkg::CH_RPAREN);
          default: push_byte(stp_pkg::CH_QUOTE);
        endcase
      end else if (pick < 84) begin
        put_comment_body($urandom_range(8));
        push_byte(stp_pkg::CH_LF);
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(pick_blank());
      end
      if ($urandom_range(1)) push_byte(pick_blank());
    end
    // Occasionally leave a token open when the text ends.
    case ($urandom_range(9))
      0: begin
        push_byte(stp_pkg::CH_DQUOTE);
        put_string_body($urandom_range(4));
        if ($urandom_range(1)) push_byte(stp_pkg::CH_BSLASH);
      end
      1: push_byte(stp_pkg::CH_TILDE);
      2: put_comment_body($urandom_range(4));
      default: ;
    endcase
    push_byte(stp_pkg::CH_NUL);
  endtask

  initial begin : stimulus
    int unsigned rnd_base;
    clear_scan();
    fork
      begin
        repeat (4) @(posedge clk_i);
        @(negedge clk_i);
        rst_ni <= 1'b1;
      end
    join_none

    // Directed texts.
    put_str("(ab1 '42)");
    push_byte(stp_pkg::CH_NUL);
    put_str("\"x\\\"\n\"~");
    push_byte(8'h80);
    put_str(";c\n?");
    push_byte(8'hFF);
    push_byte(stp_pkg::CH_NUL);
    put_str(";z");
    push_byte(stp_pkg::CH_NUL);
    put_str("\"ab");
    push_byte(stp_pkg::CH_NUL);
    push_byte(stp_pkg::CH_TILDE);
    push_byte(stp_pkg::CH_NUL);
    put_str("7");
    push_byte(stp_pkg::CH_NUL);
    push_byte(stp_pkg::CH_NUL);

    // Random texts with one long receiver hold-off, one full drain and one
    // stretch without any idling on either side.
    rnd_base = bytes_queued;
    stall_at = rnd_base + 400;
    quiet_lo = rnd_base + 1000;
    quiet_hi = rnd_base + 1300;
    while (bytes_queued < rnd_base + RANDOM_BYTES) begin
      if (!pause_armed && bytes_queued >= rnd_base + 800) begin
        pause_next  = 1'b1;
        pause_armed = 1'b1;
      end
      add_random_text();
    end

    while (text_q.size() != 0 || tokens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
